@@ sv/swm_pkg.sv @@
// ----------------------------------------------------------------------------
// swm_pkg: shared definitions for the sliding window median filter
// Default sizes, register map, and the structs passed between the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

  localparam int MAX_WINDOW_DEF  = 32;
  localparam int SAMPLE_BITS_DEF = 16;

  // Configuration register file.
  localparam int WIN_BITS = 6;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;
  localparam logic [WIN_BITS-1:0] WIN_RESET = 6'd5;

  // Register index, taken from the word address bits of paddr.
  localparam logic [CFG_AW-3:0] REG_WINDOW_SIZE = 1'b0;

  // Flags each cell shows its neighbors in the sorting chain.
  typedef struct packed {
    logic le;   // stored value is less than or equal to the new sample
    logic ge;   // this cell is at or past the cell being removed
    logic lt;   // this cell lies before the insertion point
    logic hit;  // this cell holds the oldest sample
  } swm_flags_t;

  // Static per-cell view of the window size.
  typedef struct packed {
    logic act;  // cell lies inside the window
    logic lst;  // cell is the last one of the window
  } swm_cellcfg_t;

endpackage

`default_nettype wire

@@ sv/swm_if.sv @@
// ----------------------------------------------------------------------------
// swm_in_if / swm_out_if: valid/ready channels of the median filter
// One word per accepted handshake, valid and ready both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface swm_in_if import swm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swm_out_if import swm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_BITS:0] median_x2;

  modport source (output valid, output median_x2, input ready);
  modport sink   (input valid, input median_x2, output ready);
endinterface

`default_nettype wire

@@ sv/swm_cell.sv @@
// ----------------------------------------------------------------------------
// swm_cell: one cell of the sorted window chain
// Holds one window value and its age; on each word it keeps its value,
// takes a neighbor's value, or takes the new sample.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_cell import swm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int AGE_BITS    = 5,
  parameter int INDEX       = 0
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           clr,
  input  wire                           upd,
  input  wire signed [SAMPLE_BITS-1:0]  sample,
  input  wire swm_cellcfg_t             cc,
  input  wire        [AGE_BITS-1:0]     oldest_age,
  input  wire signed [SAMPLE_BITS-1:0]  prev_val,
  input  wire        [AGE_BITS-1:0]     prev_age,
  input  wire swm_flags_t               prev_fl,
  input  wire signed [SAMPLE_BITS-1:0]  next_val,
  input  wire        [AGE_BITS-1:0]     next_age,
  input  wire swm_flags_t               next_fl,
  output logic signed [SAMPLE_BITS-1:0] val,
  output logic        [AGE_BITS-1:0]    age,
  output swm_flags_t                    fl
);

  logic signed [SAMPLE_BITS-1:0] val_r, val_nxt, src_val;
  logic        [AGE_BITS-1:0]    age_r, age_nxt, src_age;
  logic                          hit, ge, le, lt, ins;

  always_comb begin
    hit = cc.act & (age_r == oldest_age);
    ge  = prev_fl.ge | hit | cc.lst;
    le  = cc.act & (val_r <= sample);
    lt  = ge ? next_fl.le : le;

    ins     = 1'b0;
    src_val = val_r;
    src_age = age_r;
    if (lt) begin
      // Before the insertion point: close the gap left by the removed cell.
      if (ge) begin
        src_val = next_val;
        src_age = next_age;
      end
    end else if (prev_fl.lt) begin
      ins = 1'b1;
    end else if (!prev_fl.ge) begin
      // Past the insertion point and before the removed cell: shift right.
      src_val = prev_val;
      src_age = prev_age;
    end

    val_nxt = ins ? sample : src_val;
    age_nxt = ins ? '0 : src_age + AGE_BITS'(1);

    fl.hit = hit;
    fl.ge  = ge;
    fl.le  = le;
    fl.lt  = lt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      val_r <= '0;
      age_r <= AGE_BITS'(INDEX);
    end else if (upd && cc.act) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

  assign val = val_r;
  assign age = age_r;

endmodule

`default_nettype wire

@@ sv/swm_cfg.sv @@
// ----------------------------------------------------------------------------
// swm_cfg: window size register and its decoded view
// APB-style register port; turns the window size into per-cell flags.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_cfg import swm_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int AGE_BITS   = 5
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     psel,
  input  wire                     penable,
  input  wire                     pwrite,
  input  wire  [CFG_AW-1:0]       paddr,
  input  wire  [CFG_DW-1:0]       pwdata,
  output logic [CFG_DW-1:0]       prdata,
  output logic                    pready,
  output logic                    clr,
  output logic [AGE_BITS-1:0]     oldest_age,
  output swm_cellcfg_t            cc [MAX_WINDOW],
  output logic [MAX_WINDOW-1:0]   lo_sel,
  output logic [MAX_WINDOW-1:0]   hi_sel
);

  localparam int EW = $clog2(MAX_WINDOW + 1);
  localparam int CW = (EW > WIN_BITS) ? EW : WIN_BITS;

  logic [WIN_BITS-1:0] win_r;
  logic                hit_reg;
  logic [CW-1:0]       win_ext, eff_c;
  logic [EW-1:0]       eff, effm1, half, lo_idx;

  assign hit_reg = (paddr[CFG_AW-1:2] == REG_WINDOW_SIZE);
  assign clr     = psel & penable & pwrite & hit_reg;
  assign pready  = 1'b1;
  assign prdata  = hit_reg ? CFG_DW'(win_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= WIN_RESET;
    end else if (clr) begin
      win_r <= pwdata[WIN_BITS-1:0];
    end
  end

  // A size of zero acts as one; sizes above the chain length saturate.
  always_comb begin
    win_ext = CW'(win_r);
    if (win_r == '0) begin
      eff_c = CW'(1);
    end else if (win_ext > CW'(MAX_WINDOW)) begin
      eff_c = CW'(MAX_WINDOW);
    end else begin
      eff_c = win_ext;
    end
    eff    = eff_c[EW-1:0];
    effm1  = eff - EW'(1);
    half   = eff >> 1;
    lo_idx = eff[0] ? half : half - EW'(1);
  end

  assign oldest_age = effm1[AGE_BITS-1:0];

  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      cc[i].act = (EW'(i) < eff);
      cc[i].lst = (EW'(i) == effm1);
      hi_sel[i] = (EW'(i) == half);
      lo_sel[i] = (EW'(i) == lo_idx);
    end
  end

endmodule

`default_nettype wire

@@ sv/swm_med.sv @@
// ----------------------------------------------------------------------------
// swm_med: median pick and result queue
// Sums the two middle cells and queues the result in a two-word buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_med import swm_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire        [MAX_WINDOW-1:0][SAMPLE_BITS-1:0] vals,
  input  wire        [MAX_WINDOW-1:0]            lo_sel,
  input  wire        [MAX_WINDOW-1:0]            hi_sel,
  input  wire                                    fresh,
  output logic                                   room,
  swm_out_if.source                              out_m
);

  logic [SAMPLE_BITS-1:0]        lo_v, hi_v;
  logic signed [SAMPLE_BITS:0]   sum;
  logic signed [SAMPLE_BITS:0]   buf_r [2];
  logic                          wp_r, rp_r, pop;
  logic [1:0]                    cnt_r, cnt_nxt, occ;

  always_comb begin
    lo_v = '0;
    hi_v = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      lo_v = lo_v | (lo_sel[i] ? vals[i] : '0);
      hi_v = hi_v | (hi_sel[i] ? vals[i] : '0);
    end
    sum = $signed({lo_v[SAMPLE_BITS-1], lo_v}) + $signed({hi_v[SAMPLE_BITS-1], hi_v});
  end

  assign pop           = out_m.valid & out_m.ready;
  assign out_m.valid   = (cnt_r != 2'd0);
  assign out_m.median_x2 = buf_r[rp_r];
  assign occ           = cnt_r + {1'b0, fresh};
  assign room          = (occ < 2'd2) | pop;
  assign cnt_nxt       = cnt_r + {1'b0, fresh} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (fresh) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fresh) begin
      buf_r[wp_r] <= sum;
    end
  end

endmodule

`default_nettype wire

@@ sv/sliding_window_median_core.sv @@
// ----------------------------------------------------------------------------
// sliding_window_median_core: running median over the last W samples
// A sample word taken at a rising edge updates the cell chain at that edge; the
// median stage then writes its result into the result buffer, which offers it.
// Throughput: one sample word per cycle while the input is open; the input closes
// in any cycle where the output stalls while one result waits and one is on its way.
// Reset refills the window with zeros, sets the size to five and empties the
// result buffer; a window size write refills the window the same way.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_median_core import swm_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  swm_in_if.sink              in_s,
  swm_out_if.source           out_m,
  input  wire                 cfg_psel,
  input  wire                 cfg_penable,
  input  wire                 cfg_pwrite,
  input  wire  [CFG_AW-1:0]   cfg_paddr,
  input  wire  [CFG_DW-1:0]   cfg_pwdata,
  output logic [CFG_DW-1:0]   cfg_prdata,
  output logic                cfg_pready
);

  // Ages run from zero (newest) to W-1 (oldest).
  localparam int AGE_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  logic                                  accept, room, clr, fresh_r;
  logic [AGE_BITS-1:0]                   oldest_age;
  swm_cellcfg_t                          cc [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]                 lo_sel, hi_sel, hits;
  logic [MAX_WINDOW-1:0][SAMPLE_BITS-1:0] vals;
  logic [AGE_BITS-1:0]                   ages [MAX_WINDOW];
  swm_flags_t                            fls  [MAX_WINDOW];
  logic                                  sorted_ok;

  // The register block owns the window size and tells each cell whether it
  // is inside the window, whether it is the last one, and which cells hold
  // the middle values.
  swm_cfg #(
    .MAX_WINDOW (MAX_WINDOW),
    .AGE_BITS   (AGE_BITS)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .pready     (cfg_pready),
    .clr        (clr),
    .oldest_age (oldest_age),
    .cc         (cc),
    .lo_sel     (lo_sel),
    .hi_sel     (hi_sel)
  );

  // A sample word is taken whenever the result buffer can absorb its result.
  assign in_s.ready = room;
  assign accept     = in_s.valid & in_s.ready;

  // The cell chain. Every cell compares its value with the incoming sample
  // in parallel. The cell holding the oldest sample starts a "past removal"
  // flag that runs down the chain; with it and its neighbor's compare result
  // each cell decides on its own whether it keeps its value, takes the value
  // of a neighbor, or takes the new sample. The whole window thus drops the
  // oldest sample and inserts the new one in order in one update.
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] p_val, n_val, c_val;
    logic        [AGE_BITS-1:0]    p_age, n_age;
    swm_flags_t                    p_fl, n_fl;

    if (i == 0) begin : g_first
      // Nothing lies before the first cell: it is never past the removed
      // cell on entry and the insertion point is never before it.
      assign p_val = '0;
      assign p_age = '0;
      assign p_fl  = '{le: 1'b0, ge: 1'b0, lt: 1'b1, hit: 1'b0};
    end else begin : g_mid_p
      assign p_val = $signed(vals[i-1]);
      assign p_age = ages[i-1];
      assign p_fl  = fls[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_last
      assign n_val = '0;
      assign n_age = '0;
      assign n_fl  = '{le: 1'b0, ge: 1'b0, lt: 1'b0, hit: 1'b0};
    end else begin : g_mid_n
      assign n_val = $signed(vals[i+1]);
      assign n_age = ages[i+1];
      assign n_fl  = fls[i+1];
    end

    swm_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .AGE_BITS    (AGE_BITS),
      .INDEX       (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .clr        (clr),
      .upd        (accept),
      .sample     (in_s.sample),
      .cc         (cc[i]),
      .oldest_age (oldest_age),
      .prev_val   (p_val),
      .prev_age   (p_age),
      .prev_fl    (p_fl),
      .next_val   (n_val),
      .next_age   (n_age),
      .next_fl    (n_fl),
      .val        (c_val),
      .age        (ages[i]),
      .fl         (fls[i])
    );

    assign vals[i] = c_val;
    assign hits[i] = fls[i].hit;
  end

  // The cycle after a word is taken the chain holds the updated window; the
  // median stage reads the middle cells then and pushes the result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r <= 1'b0;
    end else begin
      fresh_r <= accept;
    end
  end

  swm_med #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_med (
    .clk    (clk),
    .rst_n  (rst_n),
    .vals   (vals),
    .lo_sel (lo_sel),
    .hi_sel (hi_sel),
    .fresh  (fresh_r),
    .room   (room),
    .out_m  (out_m)
  );

  // Ascending order across the active part of the chain.
  always_comb begin
    sorted_ok = 1'b1;
    for (int i = 0; i < MAX_WINDOW - 1; i++) begin
      if (cc[i+1].act && ($signed(vals[i]) > $signed(vals[i+1]))) begin
        sorted_ok = 1'b0;
      end
    end
  end

  // The window stays sorted after every update and refill.
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n) sorted_ok)
    else $error("window cells out of order");

  // Exactly one cell inside the window carries the oldest age.
  a_one_oldest: assert property (@(posedge clk) disable iff (!rst_n) $onehot(hits))
    else $error("oldest sample not unique in window");

  // Every accepted sample word is followed by a valid result word on the output.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##2 out_m.valid)
    else $error("result word missing after accepted sample");

endmodule

`default_nettype wire
